// ===== rtl/core/bto_pkg.sv =====
package bto_pkg;

  localparam logic [31:0] Q30_ONE  = 32'h4000_0000;
  localparam logic [31:0] Q30_HALF = 32'h2000_0000;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_UP_FACTOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_FACTOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB_UP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT  = 3'd4;

  typedef struct packed {
    logic [31:0] spot;
    logic [31:0] strike;
    logic        is_call;
    logic        early_ex;
  } req_t;

  typedef struct packed {
    logic [31:0] price;
    logic        overflow;
  } res_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } rnd_t;

  // Round half up, drop 30 fraction bits, saturate to 32 bits.
  function automatic rnd_t q30_round(input logic [63:0] pr);
    logic [64:0] t;
    rnd_t        r;
    t     = {1'b0, pr} + 65'(Q30_HALF);
    r.sat = |t[64:62];
    r.val = r.sat ? 32'hFFFF_FFFF : t[61:30];
    return r;
  endfunction

  function automatic logic [31:0] payoff(input logic [31:0] s, input logic [31:0] k,
                                         input logic call);
    logic [31:0] r;
    if (call) begin
      r = (s > k) ? s - k : 32'd0;
    end else begin
      r = (k > s) ? k - s : 32'd0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/bto_mul.sv =====
module bto_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  // Register the full product; rounding follows in the next stage.
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/core/bto_ram.sv =====
module bto_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1025,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/core/binomial_tree_option_pricer_core.sv =====
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+------------------------------
// request   | in        | start_i, busy_o       | req_i   (spot, strike, flags)
// result    | out       | done_o (1-cycle pulse)| res_o   (price, overflow)
// config    | in        | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
//
// A request is taken when start_i is high and busy_o is low. One request
// runs to the end before the next. Power table, leaves and node updates
// all go through the single shared multiplier, which each node update
// visits up to four times.
// Reset restores the register defaults; memories need no clearing pass.
// The result is a single-cycle pulse and cannot be stalled.
module binomial_tree_option_pricer_core #(
  parameter int unsigned MAX_STEPS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  bto_pkg::req_t                 req_i,
  output logic                          busy_o,
  output logic                          done_o,
  output bto_pkg::res_t                 res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bto_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_STEPS + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PW_U, ST_PW_D, ST_PW_W, ST_LF_RD, ST_LF_MUL, ST_LF_W,
    ST_RL_RD, ST_RL_M1, ST_RL_M2, ST_RL_M3, ST_RL_M4, ST_RL_M5, ST_RL_M6
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [31:0] up_q, down_q;
  logic [30:0] prob_q, disc_q;
  logic [10:0] steps_q;

  // Request and sequencing.
  bto_pkg::req_t req_q;
  logic [AW-1:0] n_q, s_q, i_q, k_q;
  logic          sat_q;
  bto_pkg::res_t res_q;
  logic          done_q;

  // Datapath holding registers.
  logic [31:0] ast_q, dp_q, vcar_q, vnx_q, cont_q, v_q;
  logic [63:0] acc_q;

  // Memories: table of {asset, down power}, and node values.
  logic          a_we;
  logic [AW-1:0] a_waddr, a_raddr0, a_raddr1;
  logic [63:0]   a_wdata, a_rd0, a_rd1;
  logic          n_we;
  logic [31:0]   n_wdata, n_rd0, n_rd1;
  logic [AW-1:0] n_raddr0;

  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod;
  bto_pkg::rnd_t    rnd;
  logic [30:0]      p_eff, q_eff, d_eff;
  logic [31:0]      n_eff32;
  logic [AW-1:0]    n_eff;
  logic [64:0]      mix;
  logic [31:0]      ex, node_val;
  logic             sat_nx;
  logic             accept;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign res_o       = res_q;

  // Clamp probability, discount and step count.
  always_comb begin
    p_eff   = (prob_q > 31'(bto_pkg::Q30_ONE)) ? 31'(bto_pkg::Q30_ONE) : prob_q;
    q_eff   = 31'(bto_pkg::Q30_ONE) - p_eff;
    d_eff   = (disc_q > 31'(bto_pkg::Q30_ONE)) ? 31'(bto_pkg::Q30_ONE) : disc_q;
    n_eff32 = 32'(steps_q);
    if (n_eff32 == 32'd0) begin
      n_eff32 = 32'd1;
    end else if (n_eff32 > 32'(MAX_STEPS)) begin
      n_eff32 = 32'(MAX_STEPS);
    end
    n_eff = n_eff32[AW-1:0];
  end

  // Memory control and multiplier operand selection.
  always_comb begin
    rnd      = bto_pkg::q30_round(prod);
    mix      = {1'b0, acc_q} + {1'b0, prod} + 65'(bto_pkg::Q30_HALF);
    ex       = bto_pkg::payoff(rnd.val, req_q.strike, req_q.is_call);
    node_val = (req_q.early_ex && (ex > v_q)) ? ex : v_q;
    sat_nx   = sat_q | (req_q.early_ex & rnd.sat);

    a_we     = 1'b0;
    a_waddr  = k_q;
    a_wdata  = {ast_q, rnd.val};
    a_raddr0 = ((state_q == ST_LF_RD || state_q == ST_LF_MUL || state_q == ST_LF_W)
                ? n_q : s_q) - i_q;
    a_raddr1 = i_q;
    n_we     = 1'b0;
    n_wdata  = node_val;
    n_raddr0 = AW'(i_q + 1'b1);
    mul_a    = ast_q;
    mul_b    = up_q;

    unique case (state_q)
      ST_IDLE: begin
        // Seed entry zero with spot and unity power.
        a_we    = accept;
        a_waddr = '0;
        a_wdata = {req_i.spot, bto_pkg::Q30_ONE};
      end
      ST_PW_D: begin
        mul_a = dp_q;
        mul_b = down_q;
      end
      ST_PW_W:   a_we = 1'b1;
      ST_LF_MUL: begin
        mul_a = a_rd0[63:32];
        mul_b = a_rd1[31:0];
      end
      ST_LF_W: begin
        n_we    = 1'b1;
        n_wdata = bto_pkg::payoff(rnd.val, req_q.strike, req_q.is_call);
      end
      ST_RL_M1: begin
        mul_a = vcar_q;
        mul_b = {1'b0, p_eff};
      end
      ST_RL_M2: begin
        mul_a = vnx_q;
        mul_b = {1'b0, q_eff};
      end
      ST_RL_M4: begin
        mul_a = cont_q;
        mul_b = {1'b0, d_eff};
      end
      ST_RL_M5: begin
        mul_a = a_rd0[63:32];
        mul_b = a_rd1[31:0];
      end
      ST_RL_M6:  n_we = 1'b1;
      default: begin
      end
    endcase
  end

  bto_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  bto_ram #(.WIDTH(64), .DEPTH(MAX_STEPS + 1), .AW(AW)) u_tab_ram (
    .clk_i     (clk_i),
    .we_i      (a_we),
    .waddr_i   (a_waddr),
    .wdata_i   (a_wdata),
    .raddr_a_i (a_raddr0),
    .raddr_b_i (a_raddr1),
    .rdata_a_o (a_rd0),
    .rdata_b_o (a_rd1)
  );

  // Port b watches node zero for the start of every level.
  bto_ram #(.WIDTH(32), .DEPTH(MAX_STEPS + 1), .AW(AW)) u_node_ram (
    .clk_i     (clk_i),
    .we_i      (n_we),
    .waddr_i   (i_q),
    .wdata_i   (n_wdata),
    .raddr_a_i (n_raddr0),
    .raddr_b_i ('0),
    .rdata_a_o (n_rd0),
    .rdata_b_o (n_rd1)
  );

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q    <= bto_pkg::Q30_ONE;
      down_q  <= bto_pkg::Q30_ONE;
      prob_q  <= 31'(bto_pkg::Q30_HALF);
      disc_q  <= 31'(bto_pkg::Q30_ONE);
      steps_q <= 11'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bto_pkg::CFG_UP_FACTOR:   up_q    <= cfg_data_i;
        bto_pkg::CFG_DOWN_FACTOR: down_q  <= cfg_data_i;
        bto_pkg::CFG_PROB_UP:     prob_q  <= cfg_data_i[30:0];
        bto_pkg::CFG_DISCOUNT:    disc_q  <= cfg_data_i[30:0];
        bto_pkg::CFG_STEP_COUNT:  steps_q <= cfg_data_i[10:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: state, counters, flag and the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      s_q     <= '0;
      i_q     <= '0;
      k_q     <= '0;
      sat_q   <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            n_q     <= n_eff;
            k_q     <= AW'(1);
            sat_q   <= 1'b0;
            state_q <= ST_PW_U;
          end
        end
        ST_PW_U: state_q <= ST_PW_D;
        ST_PW_D: begin
          sat_q   <= sat_q | rnd.sat;
          state_q <= ST_PW_W;
        end
        ST_PW_W: begin
          sat_q <= sat_q | rnd.sat;
          if (k_q == n_q) begin
            i_q     <= '0;
            state_q <= ST_LF_RD;
          end else begin
            k_q     <= AW'(k_q + 1'b1);
            state_q <= ST_PW_U;
          end
        end
        ST_LF_RD:  state_q <= ST_LF_MUL;
        ST_LF_MUL: state_q <= ST_LF_W;
        ST_LF_W: begin
          sat_q <= sat_q | rnd.sat;
          if (i_q == n_q) begin
            s_q     <= AW'(n_q - 1'b1);
            i_q     <= '0;
            state_q <= ST_RL_RD;
          end else begin
            i_q     <= AW'(i_q + 1'b1);
            state_q <= ST_LF_RD;
          end
        end
        ST_RL_RD: state_q <= ST_RL_M1;
        ST_RL_M1: state_q <= ST_RL_M2;
        ST_RL_M2: state_q <= ST_RL_M3;
        ST_RL_M3: state_q <= ST_RL_M4;
        ST_RL_M4: state_q <= ST_RL_M5;
        ST_RL_M5: begin
          sat_q   <= sat_q | rnd.sat;
          state_q <= ST_RL_M6;
        end
        ST_RL_M6: begin
          sat_q <= sat_nx;
          if (i_q == s_q) begin
            i_q <= '0;
            if (s_q == '0) begin
              res_q.price    <= node_val;
              res_q.overflow <= sat_nx;
              done_q         <= 1'b1;
              state_q        <= ST_IDLE;
            end else begin
              s_q     <= AW'(s_q - 1'b1);
              state_q <= ST_RL_RD;
            end
          end else begin
            i_q     <= AW'(i_q + 1'b1);
            state_q <= ST_RL_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath holding registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_q <= req_i;
          ast_q <= req_i.spot;
          dp_q  <= bto_pkg::Q30_ONE;
        end
      end
      ST_PW_D:  ast_q <= rnd.val;
      ST_PW_W:  dp_q  <= rnd.val;
      ST_RL_RD: begin
        // Node zero opens each level as the left child.
        if (i_q == '0) begin
          vcar_q <= n_rd1;
        end
      end
      ST_RL_M1: vnx_q  <= n_rd0;
      ST_RL_M2: acc_q  <= prod;
      ST_RL_M3: cont_q <= mix[61:30];
      ST_RL_M5: v_q    <= rnd.val;
      ST_RL_M6: vcar_q <= vnx_q;
      default: begin
      end
    endcase
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not raise busy");

  a_node_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_we |-> busy_o)
    else $error("node write outside a request");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(a_we && n_we))
    else $error("both memories written in one cycle");

endmodule
